[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked every clock, masked while reset is asserted
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in any cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hw/rtl/lpm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared widths, item layouts and control/status types of the route lookup.
// ----------------------------------------------------------------------------
package lpm_pkg;

    // Field widths
    localparam int ADDR_BITS = 32;
    localparam int IDX_W     = 10;
    localparam int LEN_W     = 6;
    localparam int PORT_W    = 4;
    localparam int CNT_W     = 11;

    // Stream widths (whole bytes)
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 56;

    // Parameter defaults
    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int DEFAULT_PORT_COUNT  = 16;

    // Item kinds carried in s_tuser
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Input item, last declared field in the lowest bits
    typedef struct packed {
        logic [3:0]           pad;
        logic [ADDR_BITS-1:0] lookup_addr;
        logic [PORT_W-1:0]    port_in;
        logic [ADDR_BITS-1:0] next_hop_in;
        logic [LEN_W-1:0]     prefix_len_in;
        logic [ADDR_BITS-1:0] route_prefix_in;
        logic [IDX_W-1:0]     entry_index;
    } in_item_t;

    // Result item, last declared field in the lowest bits
    typedef struct packed {
        logic [3:0]           pad;
        logic [LEN_W-1:0]     match_len;
        logic [IDX_W-1:0]     match_index;
        logic [PORT_W-1:0]    egress_port;
        logic [ADDR_BITS-1:0] hop_addr;
    } out_item_t;

    // One row of the route table
    typedef struct packed {
        logic [ADDR_BITS-1:0] prefix;
        logic [LEN_W-1:0]     len;
        logic [ADDR_BITS-1:0] hop;
        logic [PORT_W-1:0]    port;
    } route_entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture the accepted item, clear the best match
        logic wr_en;      // write the captured route into the table
        logic rd_issue;   // read the next table row of the scan
        logic out_load;   // move the result into the output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero; // no valid routes
        logic rd_last;    // current scan address is the last valid row
    } dp_stat_t;

    // Mask with len leading ones, len in 0..32
    function automatic logic [ADDR_BITS-1:0] len_mask(input logic [LEN_W-1:0] len);
        len_mask = ~({ADDR_BITS{1'b1}} >> len);
    endfunction

endpackage

[hw/rtl/lpm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_ctrl
// Sequencer: accepts one item, runs a table write or a table scan (no scan for a
// lookup with a zero route count), then hands the result to the output register.
// ----------------------------------------------------------------------------
module lpm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,    // [0] cmd
    output logic              m_tvalid,
    input  logic              m_tready,
    output lpm_pkg::dp_cmd_t  cmd,
    input  lpm_pkg::dp_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;

    // Commands to the datapath
    always_comb begin
        cmd          = '0;
        cmd.load     = accept;
        cmd.wr_en    = (state_reg == ST_WRITE);
        cmd.rd_issue = (state_reg == ST_SCAN);
        cmd.out_load = (state_reg == ST_FINISH) && out_free;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == lpm_pkg::CMD_WRITE) begin
                        state_next = ST_WRITE;
                    end else if (s_tuser == lpm_pkg::CMD_LOOKUP && stat.count_zero) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_WRITE: begin
                state_next = ST_FINISH;
            end
            ST_SCAN: begin
                if (stat.rd_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared on transfer
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/lpm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_datapath
// Route table memory, scan address counter, match compare, best-route
// registers, route count register and output payload register.
// ----------------------------------------------------------------------------
module lpm_datapath #(
    parameter int TABLE_DEPTH = lpm_pkg::DEFAULT_TABLE_DEPTH,
    parameter int PORT_COUNT  = lpm_pkg::DEFAULT_PORT_COUNT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lpm_pkg::dp_cmd_t                cmd,
    output lpm_pkg::dp_stat_t               stat,
    input  logic [lpm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            cfg_valid,
    input  logic [lpm_pkg::CNT_W-1:0]       cfg_data,
    output logic [lpm_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser
);

    localparam int          AW      = $clog2(TABLE_DEPTH);
    localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);
    localparam logic [31:0] PORTS_W = 32'(PORT_COUNT);
    localparam logic [lpm_pkg::PORT_W-1:0] PORT_MAX = lpm_pkg::PORT_W'(PORT_COUNT - 1);
    localparam logic [lpm_pkg::LEN_W-1:0]  LEN_MAX  = lpm_pkg::LEN_W'(lpm_pkg::ADDR_BITS);

    lpm_pkg::in_item_t    item;
    lpm_pkg::route_entry_t wr_entry;
    lpm_pkg::route_entry_t mem [TABLE_DEPTH];

    // Captured item
    logic [lpm_pkg::ADDR_BITS-1:0] addr_reg;
    lpm_pkg::route_entry_t         wr_entry_reg;
    logic [AW-1:0]                 wr_addr_reg;
    logic                          wr_ok_reg;
    logic [AW-1:0]                 last_reg;

    // Configuration
    logic [lpm_pkg::CNT_W-1:0]     count_reg;
    logic [31:0]                   count_w;
    logic [31:0]                   eff_count;

    // Scan pipeline
    logic [AW-1:0]                 rd_addr_reg;
    lpm_pkg::route_entry_t         q_entry_reg;
    logic [AW-1:0]                 q_idx_reg;
    logic                          q_valid_reg;
    logic                          match;
    logic                          better;

    // Best route so far
    logic                          found_reg;
    logic [lpm_pkg::LEN_W-1:0]     best_len_reg;
    logic [AW-1:0]                 best_idx_reg;
    logic [lpm_pkg::ADDR_BITS-1:0] best_hop_reg;
    logic [lpm_pkg::PORT_W-1:0]    best_port_reg;

    // Output payload
    lpm_pkg::out_item_t            out_reg;
    logic                          out_hit_reg;

    assign item = lpm_pkg::in_item_t'(s_tdata);

    // Route count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_valid) begin
            count_reg <= cfg_data;
        end
    end

    // Rows scanned: route count limited to the table depth
    assign count_w         = 32'(count_reg);
    assign eff_count       = (count_w > DEPTH_W) ? DEPTH_W : count_w;
    assign stat.count_zero = (count_reg == '0);
    assign stat.rd_last    = (rd_addr_reg == last_reg);

    // Route to be written, lengths and ports clamped
    always_comb begin
        wr_entry        = '0;
        wr_entry.prefix = item.route_prefix_in;
        wr_entry.len    = (item.prefix_len_in > LEN_MAX) ? LEN_MAX : item.prefix_len_in;
        wr_entry.hop    = item.next_hop_in;
        wr_entry.port   = (32'(item.port_in) >= PORTS_W) ? PORT_MAX : item.port_in;
    end

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg     <= item.lookup_addr;
            wr_entry_reg <= wr_entry;
            wr_addr_reg  <= AW'(item.entry_index);
            wr_ok_reg    <= (32'(item.entry_index) < DEPTH_W);
            last_reg     <= AW'(eff_count - 32'd1);
        end
    end

    // Table write port
    always_ff @(posedge aclk) begin
        if (cmd.wr_en && wr_ok_reg) begin
            mem[wr_addr_reg] <= wr_entry_reg;
        end
    end

    // Table read port, registered data
    always_ff @(posedge aclk) begin
        q_entry_reg <= mem[rd_addr_reg];
        q_idx_reg   <= rd_addr_reg;
    end

    // Scan address and read-valid tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_addr_reg <= '0;
            q_valid_reg <= 1'b0;
        end else begin
            q_valid_reg <= cmd.rd_issue;
            if (cmd.load) begin
                rd_addr_reg <= '0;
            end else if (cmd.rd_issue) begin
                rd_addr_reg <= rd_addr_reg + AW'(1);
            end
        end
    end

    // Prefix compare; strictly longer wins so the lowest index keeps ties
    assign match  = ((addr_reg ^ q_entry_reg.prefix) & lpm_pkg::len_mask(q_entry_reg.len)) == '0;
    assign better = !found_reg || (q_entry_reg.len > best_len_reg);

    // Best route registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.load) begin
            found_reg <= 1'b0;
        end else if (q_valid_reg && match && better) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            best_len_reg  <= '0;
            best_idx_reg  <= '0;
            best_hop_reg  <= '0;
            best_port_reg <= '0;
        end else if (q_valid_reg && match && better) begin
            best_len_reg  <= q_entry_reg.len;
            best_idx_reg  <= q_idx_reg;
            best_hop_reg  <= q_entry_reg.hop;
            best_port_reg <= q_entry_reg.port;
        end
    end

    // Output payload register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_hit_reg             <= found_reg;
            out_reg.pad             <= '0;
            out_reg.hop_addr        <= best_hop_reg;
            out_reg.egress_port     <= best_port_reg;
            out_reg.match_index     <= lpm_pkg::IDX_W'(best_idx_reg);
            out_reg.match_len       <= best_len_reg;
        end
    end

    assign m_tdata = out_reg;
    assign m_tuser = out_hit_reg;

endmodule

[hw/rtl/longest_prefix_match_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_prefix_match_lookup
// IPv4 longest prefix match engine over a route table in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per transfer. s_tuser selects a route write (0) or an
//   address lookup (1). A write stores prefix, length, next hop and port at
//   entry_index; a lookup scans rows 0 .. n-1, n = min(route_count, depth), one
//   row per cycle through the memory's single read port.
//   m_ channel: one result per item; m_tuser is the hit flag. Writes and
//   missed lookups return all zeros.
//   cfg_ channel: writes route_count (always ready). Write it only while idle.
//   A write runs the write and finish steps; a lookup runs the scan, drain
//   and finish steps, or goes straight to finish when n is 0.
//   A new item is taken while the previous result waits in the output
//   register; if that result is untaken and m_tready stays low, the block
//   holds in its final step.
//   Reset clears route_count and all control state. Table contents are not
//   cleared; rows must be written before a lookup reaches them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module longest_prefix_match_lookup #(
    parameter int TABLE_DEPTH = lpm_pkg::DEFAULT_TABLE_DEPTH,
    parameter int PORT_COUNT  = lpm_pkg::DEFAULT_PORT_COUNT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [9:0] entry_index, [41:10] route_prefix_in, [47:42] prefix_len_in,
    // [79:48] next_hop_in, [83:80] port_in, [115:84] lookup_addr, [119:116] zero
    input  logic [lpm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,   // [0] cmd
    // Results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] hop_addr, [35:32] egress_port, [45:36] match_index,
    // [51:46] match_len, [55:52] zero
    output logic [lpm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser,   // [0] hit
    // Route count register
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lpm_pkg::CNT_W-1:0]     cfg_data
);

    lpm_pkg::dp_cmd_t  cmd;
    lpm_pkg::dp_stat_t stat;
    logic              cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    lpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    lpm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PORT_COUNT  (PORT_COUNT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_write),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Checks
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready,
                 !s_tready, "input ready while an item is in progress")
    `ASSERT_ALWAYS(a_load_when_free, aclk, aresetn,
                   !cmd.out_load || !m_tvalid || m_tready,
                   "result loaded over an untaken result")
    `ASSERT_NEXT(a_valid_after_load, aclk, aresetn, cmd.out_load, m_tvalid,
                 "result loaded but not presented")
    `ASSERT_ALWAYS(a_no_rw_overlap, aclk, aresetn, !(cmd.wr_en && cmd.rd_issue),
                   "table write during scan")

endmodule
